FILE: rtl/sha256_pkg.sv
// Constants and helper functions shared by the SHA-256 engine.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    W_DATA   = 2'd0,
    W_LEN_HI = 2'd1,
    W_LEN_LO = 2'd2,
    W_PAD    = 2'd3
  } wsrc_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

FILE: rtl/sha256_round.sv
// One SHA-256 compression round on the working variables.
module sha256_round (
  input  logic [7:0][31:0] vin,
  input  logic [31:0]      w,
  input  logic [31:0]      k,
  output logic [7:0][31:0] vout
);
  import sha256_pkg::*;

  word_t s0, s1, ch, maj, t1, t2;

  always_comb begin
    s1  = rotr(vin[4], 6) ^ rotr(vin[4], 11) ^ rotr(vin[4], 25);
    ch  = (vin[4] & vin[5]) ^ (~vin[4] & vin[6]);
    t1  = vin[7] + s1 + ch + k + w;
    s0  = rotr(vin[0], 2) ^ rotr(vin[0], 13) ^ rotr(vin[0], 22);
    maj = (vin[0] & vin[1]) ^ (vin[0] & vin[2]) ^ (vin[1] & vin[2]);
    t2  = s0 + maj;
    vout[7] = vin[6];
    vout[6] = vin[5];
    vout[5] = vin[4];
    vout[4] = vin[3] + t1;
    vout[3] = vin[2];
    vout[2] = vin[1];
    vout[1] = vin[0];
    vout[0] = t1 + t2;
  end
endmodule

FILE: rtl/sha256_hash_engine_unit.sv
// SHA-256 engine top level: word intake, padding, schedule memory, rounds and digest output.
// Every intake word is written to the schedule memory, and the sixteenth of a block starts a
// compression of 64 rounds on the single-read-port schedule memory. Each of the first sixteen
// rounds reads w[t], waits, then runs the round. Each later round reads w[t-2], w[t-7],
// w[t-15] and w[t-16], waits while the new schedule word forms, then runs the round with the
// write back. The S_ADD state then adds the working variables into the hash words. A final
// word adds the padding words one per cycle, one or two compressions, and eight digest
// transfers. The hash words are reset to the initial values by a flip-flop array at reset
// and after each digest.
module sha256_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_word[31:0]
  input  logic [2:0]  s_tuser,   // valid_bytes[2:0]
  input  logic        s_tlast,   // final_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word[31:0]
  output logic [2:0]  m_tuser,   // word_index[2:0]
  output logic        m_tlast    // last_of_digest
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_READ, S_WAIT, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t state;
  logic [31:0] wmem [16];
  logic [31:0] rdata;
  logic [3:0]  raddr;
  logic        ren;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  logic        wen;

  logic [7:0][31:0] hv;
  logic [7:0][31:0] rv;
  logic [7:0][31:0] rv_next;
  logic [63:0] bit_len;
  logic [3:0]  fill;
  logic [5:0]  t;
  logic [1:0]  ph;
  logic [31:0] w2, w7, w15;
  logic [31:0] w_round;
  logic        fin;
  logic        pad_done;
  logic        len_hi_done;
  logic [2:0]  oidx;
  logic [31:0] w_new, w_use, g0, g1;
  logic [2:0]  nb;
  logic [31:0] keep, mark;

  always_ff @(posedge clk) begin
    if (ren) rdata <= wmem[raddr];
    if (wen) wmem[waddr] <= wdata;
  end

  always_comb begin
    g1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    g0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    w_new = g1 + w7 + g0 + rdata;
    w_use = (t < 6'd16) ? rdata : w_new;
  end

  sha256_round u_round (.vin(rv), .w(w_round), .k(round_k(t)), .vout(rv_next));

  always_comb begin
    nb = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
    case (nb[1:0])
      2'd0: begin keep = 32'h0; mark = 32'h80000000; end
      2'd1: begin keep = 32'hff000000; mark = 32'h00800000; end
      2'd2: begin keep = 32'hffff0000; mark = 32'h00008000; end
      default: begin keep = 32'hffffff00; mark = 32'h00000080; end
    endcase
  end

  // memory port: one read address per cycle
  always_comb begin
    ren = 1'b0; raddr = t[3:0];
    wen = 1'b0; waddr = fill; wdata = 32'h0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          wen = 1'b1;
          if (!s_tlast || nb == 3'd4) wdata = s_tdata;
          else wdata = (s_tdata & keep) | mark;
        end
      end
      S_PAD: begin
        wen = 1'b1;
        if (!pad_done) wdata = 32'h80000000;
        else if (fill == 4'd14) wdata = bit_len[63:32];
        else if (fill == 4'd15 && len_hi_done) wdata = bit_len[31:0];
        else wdata = 32'h0;
      end
      S_READ: begin
        ren = 1'b1;
        case (ph)
          2'd0: raddr = t[3:0] - 4'd2;
          2'd1: raddr = t[3:0] - 4'd7;
          2'd2: raddr = t[3:0] - 4'd15;
          default: raddr = t[3:0];
        endcase
      end
      S_ROUND: begin
        wen = (t >= 6'd16); waddr = t[3:0]; wdata = w_round;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = hv[oidx];
  assign m_tuser  = oidx;
  assign m_tlast  = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 8; i++) hv[i] <= init_h(3'(i));
      bit_len <= 64'h0; fill <= 4'h0; t <= 6'h0; ph <= 2'h0;
      fin <= 1'b0; pad_done <= 1'b0; len_hi_done <= 1'b0; oidx <= 3'h0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            fill <= fill + 4'd1;
            if (!s_tlast) begin
              bit_len <= bit_len + 64'd32;
              fin <= 1'b0;
            end else begin
              bit_len <= bit_len + {58'h0, nb, 3'h0};
              fin <= 1'b1;
              pad_done <= (nb != 3'd4);
              len_hi_done <= 1'b0;
            end
            if (fill == 4'd15) begin
              state <= S_READ; t <= 6'h0; ph <= 2'd3; rv <= hv;
            end else if (s_tlast) state <= S_PAD;
          end
        end
        S_PAD: begin
          fill <= fill + 4'd1;
          pad_done <= 1'b1;
          if (pad_done && fill == 4'd14) len_hi_done <= 1'b1;
          if (fill == 4'd15) begin
            state <= S_READ; t <= 6'h0; ph <= 2'd3; rv <= hv;
          end
        end
        S_READ: begin
          case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin w2 <= rdata; ph <= 2'd2; end
            2'd2: begin w7 <= rdata; ph <= 2'd3; end
            default: begin
              if (t >= 6'd16) w15 <= rdata;
              state <= S_WAIT;
            end
          endcase
        end
        S_WAIT: begin
          w_round <= w_use;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rv <= rv_next;
          t <= t + 6'd1;
          ph <= (t + 6'd1 >= 6'd16) ? 2'd0 : 2'd3;
          state <= (t == 6'd63) ? S_ADD : S_READ;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + rv[i];
          if (!fin) state <= S_IDLE;
          else if (len_hi_done) begin state <= S_OUT; oidx <= 3'h0; end
          else state <= S_PAD;
        end
        S_OUT: begin
          if (m_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= S_IDLE;
              for (int i = 0; i < 8; i++) hv[i] <= init_h(3'(i));
              bit_len <= 64'h0; fill <= 4'h0; fin <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read data is registered and lands in the cycle after its address: w[t-2] in phase 1,
  // w[t-7] in phase 2, w[t-15] in phase 3 and w[t-16] (or w[t]) in the wait cycle.

  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("intake open while digest pending");
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> fill == 4'h0) else $error("digest with partial block");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to intake");
endmodule
